// File: hw/rtl/wbpq_pkg.sv
package wbpq_pkg;

    // input word kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_POP    = 1'b1;

    // result status codes
    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_DROPPED = 3'd1,
        ST_FULL    = 3'd2,
        ST_POPPED  = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    // non-empty map is searched in groups of this many buckets
    localparam int GRP   = 16;
    localparam int GRP_W = $clog2(GRP);

    typedef struct packed {
        logic rd;
        logic wr_pair;
        logic wr_link;
    } t_ent_ctl;

    typedef struct packed {
        logic rd;
        logic wr;
        logic set;
        logic clr;
        logic grp_ld;
    } t_bkt_ctl;

    typedef struct packed {
        logic rd;
        logic alloc;
        logic rel;
    } t_free_ctl;

endpackage

// File: hw/rtl/wbpq_entry_mem.sv
module wbpq_entry_mem #(
    parameter int CAPACITY = 1024
) (
    input  logic                        i_clk,
    input  wbpq_pkg::t_ent_ctl          i_ctl,
    input  logic [$clog2(CAPACITY)-1:0] i_rd_addr,
    input  logic [$clog2(CAPACITY)-1:0] i_pair_addr,
    input  logic [31:0]                 i_pair_data,
    input  logic [$clog2(CAPACITY)-1:0] i_link_addr,
    input  logic [$clog2(CAPACITY)-1:0] i_link_data,
    output logic [31:0]                 o_rd_pair,
    output logic [$clog2(CAPACITY)-1:0] o_rd_link
);
    import wbpq_pkg::*;

    localparam int IW = $clog2(CAPACITY);

    // pair store: second id high, first id low
    logic [31:0]   r_pair_mem [CAPACITY];
    // next entry within the same bucket
    logic [IW-1:0] r_link_mem [CAPACITY];
    logic [31:0]   r_rd_pair;
    logic [IW-1:0] r_rd_link;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_pair) begin
            r_pair_mem[i_pair_addr] <= i_pair_data;
        end
        if (i_ctl.rd) begin
            r_rd_pair <= r_pair_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_link) begin
            r_link_mem[i_link_addr] <= i_link_data;
        end
        if (i_ctl.rd) begin
            r_rd_link <= r_link_mem[i_rd_addr];
        end
    end

    assign o_rd_pair = r_rd_pair;
    assign o_rd_link = r_rd_link;

endmodule

// File: hw/rtl/wbpq_free_list.sv
module wbpq_free_list #(
    parameter int CAPACITY = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wbpq_pkg::t_free_ctl         i_ctl,
    input  logic [$clog2(CAPACITY)-1:0] i_rel_idx,
    output logic [$clog2(CAPACITY)-1:0] o_alloc_idx
);
    import wbpq_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // recycled entries on a stack, never-used entries handed out by count
    logic [IW-1:0] r_stack [CAPACITY];
    logic [IW-1:0] r_rd_data;
    logic [CW-1:0] r_free_cnt;
    logic [CW-1:0] r_fresh;
    logic [CW-1:0] w_top;

    assign w_top = r_free_cnt - CW'(1);

    always_ff @(posedge i_clk) begin
        if (i_ctl.rel) begin
            r_stack[r_free_cnt[IW-1:0]] <= i_rel_idx;
        end
        if (i_ctl.rd) begin
            r_rd_data <= r_stack[w_top[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_cnt <= '0;
            r_fresh    <= '0;
        end else if (i_ctl.rel) begin
            r_free_cnt <= r_free_cnt + CW'(1);
        end else if (i_ctl.alloc) begin
            if (r_free_cnt != '0) begin
                r_free_cnt <= w_top;
            end else begin
                r_fresh <= r_fresh + CW'(1);
            end
        end
    end

    assign o_alloc_idx = (r_free_cnt != '0) ? r_rd_data : r_fresh[IW-1:0];

endmodule

// File: hw/rtl/wbpq_bucket.sv
module wbpq_bucket #(
    parameter int NUM_WEIGHTS = 256,
    parameter int CAPACITY    = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  wbpq_pkg::t_bkt_ctl             i_ctl,
    input  logic [$clog2(NUM_WEIGHTS)-1:0] i_addr,
    input  logic [$clog2(CAPACITY)-1:0]    i_wr_head,
    input  logic [$clog2(CAPACITY)-1:0]    i_wr_tail,
    output logic [$clog2(CAPACITY)-1:0]    o_rd_head,
    output logic [$clog2(CAPACITY)-1:0]    o_rd_tail,
    output logic                           o_addr_nonempty,
    output logic                           o_any,
    output logic [$clog2(NUM_WEIGHTS)-1:0] o_found
);
    import wbpq_pkg::*;

    localparam int WW     = $clog2(NUM_WEIGHTS);
    localparam int IW     = $clog2(CAPACITY);
    localparam int NG_RAW = (NUM_WEIGHTS + GRP - 1) / GRP;
    localparam int NG     = (NG_RAW < 2) ? 2 : NG_RAW;
    localparam int GW     = $clog2(NG);

    // head and tail per bucket, one word
    logic [2*IW-1:0]        r_mem [NUM_WEIGHTS];
    logic [IW-1:0]          r_rd_head;
    logic [IW-1:0]          r_rd_tail;
    logic [NUM_WEIGHTS-1:0] r_map;
    logic                   r_any;
    logic [GW-1:0]          r_grp;

    logic [NG*GRP-1:0]      w_pad;
    logic [GRP-1:0]         w_grp_bits [NG];
    logic [NG-1:0]          w_grp_any;
    logic [GW-1:0]          w_first_grp;
    logic [GRP-1:0]         w_bits;
    logic [GRP_W-1:0]       w_bit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_addr] <= {i_wr_head, i_wr_tail};
        end
        if (i_ctl.rd) begin
            {r_rd_head, r_rd_tail} <= r_mem[i_addr];
        end
    end

    // first level: which groups hold a non-empty bucket
    always_comb begin
        w_pad = '0;
        w_pad[NUM_WEIGHTS-1:0] = r_map;
        for (int g = 0; g < NG; g++) begin
            w_grp_bits[g] = w_pad[g*GRP +: GRP];
            w_grp_any[g]  = |w_pad[g*GRP +: GRP];
        end
        w_first_grp = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (w_grp_any[g]) begin
                w_first_grp = GW'(g);
            end
        end
    end

    // second level: lightest bucket inside the registered group
    always_comb begin
        w_bits = w_grp_bits[r_grp];
        w_bit  = '0;
        for (int j = GRP - 1; j >= 0; j--) begin
            if (w_bits[j]) begin
                w_bit = GRP_W'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= '0;
            r_any <= 1'b0;
            r_grp <= '0;
        end else begin
            if (i_ctl.set) begin
                r_map[i_addr] <= 1'b1;
            end else if (i_ctl.clr) begin
                r_map[i_addr] <= 1'b0;
            end
            if (i_ctl.grp_ld) begin
                r_any <= |w_grp_any;
                r_grp <= w_first_grp;
            end
        end
    end

    assign o_rd_head       = r_rd_head;
    assign o_rd_tail       = r_rd_tail;
    assign o_addr_nonempty = r_map[i_addr];
    assign o_any           = r_any;
    assign o_found         = WW'({r_grp, w_bit});

endmodule

// File: hw/rtl/weight_bucketed_pair_queue_top.sv
// Priority queue of pair handles ordered by weight, first in first out among
// equal weights. An insert word clamps its signed raw weight into
// 0..NUM_WEIGHTS-1, drops the pair when that weight is above the configured
// weight limit, refuses it when CAPACITY pairs are held, and otherwise appends
// it to the linked list of its weight bucket. A pop word takes the oldest pair
// of the lightest non-empty bucket or reports empty. Every input word gives
// exactly one result word. Items are handled one at a time; an insert runs
// the checks and then, unless dropped or refused, the write, and a pop runs
// the two-level search over the non-empty map (group, then bucket), then the
// dependent reads of the bucket pointer memory and the entry memory, each a
// registered read, and then the unlink, unless the map is empty. Each result
// then waits until the output register is free to take it. The next word is
// taken in the same cycle a result is loaded into the output register, so a
// result waiting on the output does not hold off the next item's work. The
// configuration port is ready whenever reset is released; write it only while
// the queue is idle. No clearing pass follows reset: never-used entries are
// handed out by a count, so the queue accepts words right after reset.
module weight_bucketed_pair_queue_top #(
    parameter int NUM_WEIGHTS = 256,
    parameter int CAPACITY    = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic signed [10:0] i_cfg_data,
    // input words
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_kind,
    input  logic signed [15:0] i_raw_weight,
    input  logic [15:0]        i_first_id,
    input  logic [15:0]        i_second_id,
    // result words
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_status,
    output logic [15:0]        o_out_first,
    output logic [15:0]        o_out_second,
    output logic [7:0]         o_out_weight,
    output logic [10:0]        o_pending
);
    import wbpq_pkg::*;

    localparam int WW = $clog2(NUM_WEIGHTS);
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CHK,  // clamp, limit and fullness checks, issue pointer reads
        S_INS_WR,   // write entry, link the old tail, update bucket pointers
        S_POP_GRP,  // register first non-empty group
        S_POP_BIT,  // pick lightest bucket, read its pointers
        S_POP_BKT,  // read head entry
        S_POP_ENT,  // unlink head, recycle entry
        S_DONE      // result waits for the output register
    } t_state;

    t_state              r_state;
    logic [15:0]         r_raw;
    logic [15:0]         r_first;
    logic [15:0]         r_second;
    logic [WW-1:0]       r_wt;
    t_status             r_res_status;
    logic [15:0]         r_res_first;
    logic [15:0]         r_res_second;
    logic [CW-1:0]       r_held;
    logic signed [10:0]  r_max;

    logic                r_out_valid;
    logic [2:0]          r_o_status;
    logic [15:0]         r_o_first;
    logic [15:0]         r_o_second;
    logic [7:0]          r_o_weight;
    logic [10:0]         r_o_pending;

    // submodule control and data
    t_ent_ctl            w_ent_ctl;
    t_bkt_ctl            w_bkt_ctl;
    t_free_ctl           w_free_ctl;
    logic [WW-1:0]       w_bkt_addr;
    logic [IW-1:0]       w_bkt_wr_head;
    logic [IW-1:0]       w_rd_head;
    logic [IW-1:0]       w_rd_tail;
    logic                w_addr_nonempty;
    logic                w_any;
    logic [WW-1:0]       w_found;
    logic [31:0]         w_rd_pair;
    logic [IW-1:0]       w_rd_link;
    logic [IW-1:0]       w_alloc_idx;

    logic [WW-1:0]       w_clamp;
    logic                w_drop;
    logic                w_full;
    logic                w_out_free;
    logic                w_in_acc;

    // clamp the raw weight into the bucket range
    always_comb begin
        if (r_raw[15]) begin
            w_clamp = '0;
        end else if (r_raw >= 16'(NUM_WEIGHTS)) begin
            w_clamp = WW'(NUM_WEIGHTS - 1);
        end else begin
            w_clamp = WW'(r_raw);
        end
    end

    // limit check is signed: a negative limit drops every insert
    assign w_drop = $signed({1'b0, 11'(w_clamp)}) > $signed({r_max[10], r_max});
    assign w_full = (r_held == CW'(CAPACITY));

    // no word is taken while reset is held
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = i_rst_n &&
                        ((r_state == S_IDLE) || ((r_state == S_DONE) && w_out_free));
    assign w_in_acc   = i_in_valid && o_in_ready;

    // memory strobes follow the state
    always_comb begin
        w_ent_ctl     = '0;
        w_bkt_ctl     = '0;
        w_free_ctl    = '0;
        w_bkt_addr    = r_wt;
        w_bkt_wr_head = w_alloc_idx;
        unique case (r_state)
            S_INS_CHK: begin
                w_bkt_addr    = w_clamp;
                w_bkt_ctl.rd  = !w_drop && !w_full;
                w_free_ctl.rd = !w_drop && !w_full;
            end
            S_INS_WR: begin
                w_ent_ctl.wr_pair = 1'b1;
                w_ent_ctl.wr_link = w_addr_nonempty;
                w_bkt_ctl.wr      = 1'b1;
                w_bkt_ctl.set     = 1'b1;
                w_free_ctl.alloc  = 1'b1;
                w_bkt_wr_head     = w_addr_nonempty ? w_rd_head : w_alloc_idx;
            end
            S_POP_GRP: begin
                w_bkt_ctl.grp_ld = 1'b1;
            end
            S_POP_BIT: begin
                w_bkt_addr   = w_found;
                w_bkt_ctl.rd = w_any;
            end
            S_POP_BKT: begin
                w_ent_ctl.rd = 1'b1;
            end
            S_POP_ENT: begin
                // last entry of the bucket: mark empty, else advance head
                w_bkt_ctl.clr  = (w_rd_head == w_rd_tail);
                w_bkt_ctl.wr   = (w_rd_head != w_rd_tail);
                w_bkt_wr_head  = w_rd_link;
                w_free_ctl.rel = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_max       <= 11'sd1023;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
            end

            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                end
                S_INS_CHK: begin
                    r_wt         <= w_clamp;
                    r_res_first  <= '0;
                    r_res_second <= '0;
                    if (w_drop) begin
                        r_res_status <= ST_DROPPED;
                        r_state      <= S_DONE;
                    end else if (w_full) begin
                        r_res_status <= ST_FULL;
                        r_state      <= S_DONE;
                    end else begin
                        r_state <= S_INS_WR;
                    end
                end
                S_INS_WR: begin
                    r_held       <= r_held + CW'(1);
                    r_res_status <= ST_STORED;
                    r_state      <= S_DONE;
                end
                S_POP_GRP: begin
                    r_state <= S_POP_BIT;
                end
                S_POP_BIT: begin
                    r_res_first  <= '0;
                    r_res_second <= '0;
                    if (w_any) begin
                        r_wt    <= w_found;
                        r_state <= S_POP_BKT;
                    end else begin
                        r_wt         <= '0;
                        r_res_status <= ST_EMPTY;
                        r_state      <= S_DONE;
                    end
                end
                S_POP_BKT: begin
                    r_state <= S_POP_ENT;
                end
                S_POP_ENT: begin
                    r_held       <= r_held - CW'(1);
                    r_res_first  <= w_rd_pair[15:0];
                    r_res_second <= w_rd_pair[31:16];
                    r_res_status <= ST_POPPED;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_status  <= r_res_status;
                        r_o_first   <= r_res_first;
                        r_o_second  <= r_res_second;
                        r_o_weight  <= 8'(r_wt);
                        r_o_pending <= 11'(r_held);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // take the next word, also in the cycle the result is loaded
            if (w_in_acc) begin
                r_raw    <= i_raw_weight;
                r_first  <= i_first_id;
                r_second <= i_second_id;
                r_state  <= (i_kind == KIND_POP) ? S_POP_GRP : S_INS_CHK;
            end
        end
    end

    wbpq_bucket #(
        .NUM_WEIGHTS (NUM_WEIGHTS),
        .CAPACITY    (CAPACITY)
    ) u_bucket (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_bkt_ctl),
        .i_addr          (w_bkt_addr),
        .i_wr_head       (w_bkt_wr_head),
        .i_wr_tail       ((r_state == S_POP_ENT) ? w_rd_tail : w_alloc_idx),
        .o_rd_head       (w_rd_head),
        .o_rd_tail       (w_rd_tail),
        .o_addr_nonempty (w_addr_nonempty),
        .o_any           (w_any),
        .o_found         (w_found)
    );

    wbpq_entry_mem #(
        .CAPACITY (CAPACITY)
    ) u_entry_mem (
        .i_clk       (i_clk),
        .i_ctl       (w_ent_ctl),
        .i_rd_addr   (w_rd_head),
        .i_pair_addr (w_alloc_idx),
        .i_pair_data ({r_second, r_first}),
        .i_link_addr (w_rd_tail),
        .i_link_data (w_alloc_idx),
        .o_rd_pair   (w_rd_pair),
        .o_rd_link   (w_rd_link)
    );

    wbpq_free_list #(
        .CAPACITY (CAPACITY)
    ) u_free_list (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_free_ctl),
        .i_rel_idx   (w_rd_head),
        .o_alloc_idx (w_alloc_idx)
    );

    assign o_cfg_ready  = i_rst_n;
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_o_status;
    assign o_out_first  = r_o_first;
    assign o_out_second = r_o_second;
    assign o_out_weight = r_o_weight;
    assign o_pending    = r_o_pending;

endmodule
